/* sv/refresh_rate_step_limiter_assert.svh */
// ---------------------------------------------------------------------------
// Refresh rate step limiter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef REFRESH_RATE_STEP_LIMITER_ASSERT_SVH
`define REFRESH_RATE_STEP_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rrsl_pkg.sv */
// ---------------------------------------------------------------------------
// Refresh rate step limiter package
// Widths, codes and shared structures for the step limiter modules.
// ---------------------------------------------------------------------------
package rrsl_pkg;

  // Number of table slots taken into account (two to eight).
  localparam int RATE_SLOTS = 8;

  localparam int RATE_W  = 10;
  localparam int TIME_W  = 48;
  localparam int TMO_W   = 16;
  localparam int CNT_W   = 4;
  localparam int ENTRY_W = 16;
  localparam int TBL_W   = 64;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;
  // Width of the saturated table count.
  localparam int NUM_W   = $clog2(RATE_SLOTS + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TMO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DN_TMO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TBL_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TBL_HIGH = 3'd4;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [RATE_W-1:0] vote_rate;
    logic [TIME_W-1:0] now_ms;
    logic              high_light;
  } item_t;

  typedef struct packed {
    logic [TMO_W-1:0] up_tmo;
    logic [TMO_W-1:0] dn_tmo;
    logic [CNT_W-1:0] rate_count;
    logic [TBL_W-1:0] tbl_low;
    logic [TBL_W-1:0] tbl_high;
  } cfg_t;

  // Table lookup results for the item in flight.
  typedef struct packed {
    logic               up;
    logic               cur_found;
    logic               vote_found;
    logic               next_ok;
    logic [ENTRY_W-1:0] next_rate;
  } lkp_t;

  typedef struct packed {
    logic [RATE_W-1:0] applied_rate;
    dir_t              direction;
    logic              step_started;
    logic [TMO_W-1:0]  step_timeout_ms;
    logic              cancel_task;
  } res_t;

endpackage

/* sv/rrsl_lookup.sv */
// ---------------------------------------------------------------------------
// Refresh rate step limiter table lookup
// Parallel compare of the current rate and the vote against the rate table,
// giving the neighbouring entry in the step direction.
// ---------------------------------------------------------------------------
module rrsl_lookup (
  input  rrsl_pkg::cfg_t                  cfg,
  input  logic [rrsl_pkg::RATE_W-1:0]     cur_rate,
  input  logic [rrsl_pkg::RATE_W-1:0]     vote_rate,
  output rrsl_pkg::lkp_t                  lkp
);
  import rrsl_pkg::*;

  logic [2*TBL_W-1:0]     tbl_all;
  logic [ENTRY_W-1:0]     entry [RATE_SLOTS];
  logic [NUM_W-1:0]       num;
  logic [RATE_SLOTS-1:0]  valid;
  logic [RATE_SLOTS-1:0]  ge;
  logic [RATE_SLOTS-1:0]  first;
  logic [RATE_SLOTS-1:0]  sel;
  logic [RATE_SLOTS-1:0]  hit_cur;
  logic [RATE_SLOTS-1:0]  hit_vote;
  logic [ENTRY_W-1:0]     next_rate;
  logic                   seen;
  logic                   up;

  assign tbl_all = {cfg.tbl_high, cfg.tbl_low};
  assign up      = cur_rate < vote_rate;

  // A count above the slot number saturates.
  assign num = (cfg.rate_count > CNT_W'(RATE_SLOTS)) ? NUM_W'(RATE_SLOTS)
                                                     : NUM_W'(cfg.rate_count);

  // Per-slot compares.
  always_comb begin
    for (int i = 0; i < RATE_SLOTS; i++) begin
      entry[i]    = tbl_all[i*ENTRY_W +: ENTRY_W];
      valid[i]    = NUM_W'(i) < num;
      ge[i]       = valid[i] && (entry[i] >= ENTRY_W'(cur_rate));
      hit_vote[i] = valid[i] && (entry[i] == ENTRY_W'(vote_rate));
    end
  end

  // The first valid entry not below the current rate.
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < RATE_SLOTS; i++) begin
      first[i] = ge[i] && !seen;
      seen     = seen || ge[i];
    end
  end

  always_comb begin
    for (int i = 0; i < RATE_SLOTS; i++) begin
      hit_cur[i] = first[i] && (entry[i] == ENTRY_W'(cur_rate));
    end
  end

  // Neighbour slot in the step direction, as a one-hot mask.
  assign sel = up ? (first << 1) : (first >> 1);

  always_comb begin
    next_rate = '0;
    for (int i = 0; i < RATE_SLOTS; i++) begin
      if (sel[i] && valid[i]) begin
        next_rate = next_rate | entry[i];
      end
    end
  end

  assign lkp.up         = up;
  assign lkp.cur_found  = |hit_cur;
  assign lkp.vote_found = |hit_vote;
  assign lkp.next_ok    = |(sel & valid);
  assign lkp.next_rate  = next_rate;

endmodule

/* sv/rrsl_core.sv */
// ---------------------------------------------------------------------------
// Refresh rate step limiter decision core
// Holds the current rate, step direction and step end time, and works out
// the result for the item in the input register.
// ---------------------------------------------------------------------------
module rrsl_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  rrsl_pkg::item_t              item,
  input  rrsl_pkg::cfg_t               cfg,
  input  rrsl_pkg::lkp_t               lkp,
  output logic [rrsl_pkg::RATE_W-1:0]  cur_rate,
  output rrsl_pkg::res_t               res
);
  import rrsl_pkg::*;

  logic [RATE_W-1:0] cur_rate_r, cur_rate_nxt;
  dir_t              dir_r, dir_nxt;
  logic [TIME_W-1:0] end_time_r, end_time_nxt;

  logic              bypass;
  logic              expired;
  logic              jump;
  logic [TMO_W-1:0]  tmo;
  dir_t              want;
  logic [TIME_W-1:0] end_sum;

  assign cur_rate = cur_rate_r;

  assign bypass  = (cfg.up_tmo == '0) && (cfg.dn_tmo == '0);
  assign expired = item.now_ms >= end_time_r;
  assign tmo     = lkp.up ? cfg.up_tmo : cfg.dn_tmo;
  assign want    = lkp.up ? DIR_UP : DIR_DOWN;
  assign end_sum = item.now_ms + {{(TIME_W-TMO_W){1'b0}}, tmo};
  assign jump    = (tmo == '0) || item.high_light || !lkp.cur_found ||
                   !lkp.vote_found || !lkp.next_ok;

  // Step decision for one item.
  always_comb begin
    cur_rate_nxt        = cur_rate_r;
    dir_nxt             = dir_r;
    end_time_nxt        = end_time_r;
    res.applied_rate    = item.vote_rate;
    res.step_started    = 1'b0;
    res.step_timeout_ms = '0;
    res.cancel_task     = 1'b0;
    priority if (bypass) begin
      res.applied_rate = item.vote_rate;
    end else if (cur_rate_r == item.vote_rate) begin
      // Target reached: the step ends once its hold time is over.
      if ((dir_r != DIR_NONE) && expired) begin
        dir_nxt         = DIR_NONE;
        res.cancel_task = 1'b1;
      end
    end else if (jump) begin
      dir_nxt         = DIR_NONE;
      cur_rate_nxt    = item.vote_rate;
      res.cancel_task = 1'b1;
    end else begin
      // Start a new step unless one in the same direction is still holding.
      if ((dir_r != want) || expired) begin
        dir_nxt             = want;
        end_time_nxt        = end_sum;
        cur_rate_nxt        = lkp.next_rate[RATE_W-1:0];
        res.step_started    = 1'b1;
        res.step_timeout_ms = tmo;
      end
      res.applied_rate = cur_rate_nxt;
    end
    res.direction = dir_nxt;
  end

  // State update when the item moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_rate_r <= '0;
      dir_r      <= DIR_NONE;
      end_time_r <= '0;
    end else if (adv) begin
      cur_rate_r <= cur_rate_nxt;
      dir_r      <= dir_nxt;
      end_time_r <= end_time_nxt;
    end
  end

endmodule

/* sv/refresh_rate_step_limiter.sv */
// ---------------------------------------------------------------------------
// Refresh rate step limiter
// Walks the applied display refresh rate toward the voted rate one table
// entry at a time, holding each step for a programmable time, or jumps to it.
// ---------------------------------------------------------------------------
// Usage:
//   Input items (vote rate, millisecond time, light flag) arrive on the in_
//   channel; one result item per input leaves on the out_ channel. Both
//   channels use valid and stall; an item moves when valid is high and
//   stall is low.
//   An accepted item sits in the input register, where the table lookup,
//   step decision and end-time add run, and is then registered in the
//   output register. One item per cycle is sustained while the receiver
//   does not stall; the combinational step decision sets that rate.
//   When the receiver stalls, the output register holds its item; the input
//   register then stalls the sender only if it is also full.
//   The cfg_ port writes timeouts, table count and table words. The user
//   uses it only while the block is idle; the block does not enforce it.
//   Synchronous reset clears the registers, the current rate, the step
//   direction and end time, and empties both pipeline registers.
// ---------------------------------------------------------------------------
module refresh_rate_step_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [rrsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrsl_pkg::CFG_W-1:0]        cfg_wdata,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rrsl_pkg::RATE_W-1:0]       in_vote_rate,
  input  logic [rrsl_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              in_high_light,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rrsl_pkg::RATE_W-1:0]       out_applied_rate,
  output logic [1:0]                        out_direction,
  output logic                              out_step_started,
  output logic [rrsl_pkg::TMO_W-1:0]        out_step_timeout_ms,
  output logic                              out_cancel_task
);
  import rrsl_pkg::*;

  `include "refresh_rate_step_limiter_assert.svh"

  cfg_t              cfg_r;
  logic              in_vld_r;
  item_t             in_item_r;
  logic              out_vld_r;
  res_t              out_res_r;
  logic              adv;
  lkp_t              lkp;
  res_t              res;
  logic [RATE_W-1:0] cur_rate;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_UP_TMO:   cfg_r.up_tmo     <= cfg_wdata[TMO_W-1:0];
        CFG_DN_TMO:   cfg_r.dn_tmo     <= cfg_wdata[TMO_W-1:0];
        CFG_COUNT:    cfg_r.rate_count <= cfg_wdata[CNT_W-1:0];
        CFG_TBL_LOW:  cfg_r.tbl_low    <= cfg_wdata[TBL_W-1:0];
        CFG_TBL_HIGH: cfg_r.tbl_high   <= cfg_wdata[TBL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign adv      = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.vote_rate  <= in_vote_rate;
      in_item_r.now_ms     <= in_now_ms;
      in_item_r.high_light <= in_high_light;
    end
  end

  rrsl_lookup u_lookup (
    .cfg       (cfg_r),
    .cur_rate  (cur_rate),
    .vote_rate (in_item_r.vote_rate),
    .lkp       (lkp)
  );

  rrsl_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (in_item_r),
    .cfg      (cfg_r),
    .lkp      (lkp),
    .cur_rate (cur_rate),
    .res      (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= adv || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_applied_rate    = out_res_r.applied_rate;
  assign out_direction       = out_res_r.direction;
  assign out_step_started    = out_res_r.step_started;
  assign out_step_timeout_ms = out_res_r.step_timeout_ms;
  assign out_cancel_task     = out_res_r.cancel_task;

  // Checks on the step decision and the pipeline.
  `RRSL_ASSERT_SAME(a_start_has_dir, out_vld_r && out_res_r.step_started,
    out_res_r.direction != DIR_NONE && out_res_r.step_timeout_ms != '0,
    "step started without direction or timeout")
  `RRSL_ASSERT_SAME(a_cancel_no_dir, out_vld_r && out_res_r.cancel_task,
    out_res_r.direction == DIR_NONE && !out_res_r.step_started,
    "cancel with a step still active")
  `RRSL_ASSERT_SAME(a_no_timeout_idle, out_vld_r && !out_res_r.step_started,
    out_res_r.step_timeout_ms == '0, "timeout reported without a new step")
  `RRSL_ASSERT_NEXT(a_adv_fills_out, adv, out_vld_r,
    "item left the input register but output is empty")

endmodule
